/* hdl/gncd_pkg.sv */
// ----------------------------------------------------------------------------
// gncd_pkg
// Shared constants, types and tables for the gradient noise corner dot block.
// ----------------------------------------------------------------------------
package gncd_pkg;

    localparam int CordicStagesDef = 16;
    localparam int GradFracDef     = 15;
    localparam int MaxStages       = 32;

    localparam logic [31:0] HashK1 = 32'h9E37_79B9;
    localparam logic [31:0] HashK2 = 32'h85EB_CA77;
    localparam logic signed [33:0] CordicX0 = 34'sd652032874;

    localparam int OutW  = 34;
    localparam int CrdW  = 34;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001; default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // offsets carried beside the angle through the pipe
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } t_ofs;

    typedef struct packed {
        logic          flip;
        logic [31:0]   ang;
        t_ofs          ofs;
    } t_hash_out;

endpackage

/* hdl/gncd_hash.sv */
// ----------------------------------------------------------------------------
// gncd_hash
// Corner hash pipeline: five stages of multiplies and rotate-XORs, plus offsets.
// ----------------------------------------------------------------------------
module gncd_hash (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [31:0]              i_seed,
    input  logic signed [15:0]       i_corner_x,
    input  logic signed [15:0]       i_corner_y,
    input  logic signed [31:0]       i_point_x,
    input  logic signed [31:0]       i_point_y,
    output logic                     o_valid,
    output gncd_pkg::t_hash_out      o_data
);
    localparam int Ns = 5;

    logic [Ns-1:0]   r_v;
    logic [31:0]     r_a [Ns];
    logic [31:0]     r_b [Ns];
    gncd_pkg::t_ofs  r_o [Ns];
    logic [31:0]     r_k2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Ns-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_k2 <= i_seed * gncd_pkg::HashK2;
        if (i_en) begin
            // stage 0: a *= seed, offsets
            r_a[0] <= 32'({{16{i_corner_x[15]}}, i_corner_x} * i_seed);
            r_b[0] <= {{16{i_corner_y[15]}}, i_corner_y};
            r_o[0].dx <= 33'(i_point_x) - 33'(signed'({i_corner_x, 16'h0}));
            r_o[0].dy <= 33'(i_point_y) - 33'(signed'({i_corner_y, 16'h0}));
            // stage 1: b ^= rotl16(a)
            r_a[1] <= r_a[0];
            r_b[1] <= r_b[0] ^ {r_a[0][15:0], r_a[0][31:16]};
            r_o[1] <= r_o[0];
            // stage 2: b *= seed ^ K1
            r_a[2] <= r_a[1];
            r_b[2] <= 32'(r_b[1] * (i_seed ^ gncd_pkg::HashK1));
            r_o[2] <= r_o[1];
            // stage 3: a ^= rotl16(b)
            r_a[3] <= r_a[2] ^ {r_b[2][15:0], r_b[2][31:16]};
            r_b[3] <= r_b[2];
            r_o[3] <= r_o[2];
            // stage 4: a *= seed * K2
            r_a[4] <= 32'(r_a[3] * r_k2);
            r_b[4] <= r_b[3];
            r_o[4] <= r_o[3];
        end
    end

    assign o_valid     = r_v[Ns-1];
    assign o_data.flip = r_a[Ns-1][31] ^ r_a[Ns-1][30];
    assign o_data.ang  = r_a[Ns-1];
    assign o_data.ofs  = r_o[Ns-1];
endmodule

/* hdl/gncd_cordic.sv */
// ----------------------------------------------------------------------------
// gncd_cordic
// Rotation-mode CORDIC, one registered stage per iteration, with rounding.
// ----------------------------------------------------------------------------
module gncd_cordic #(
    parameter int CORDIC_STAGES      = gncd_pkg::CordicStagesDef,
    parameter int GRADIENT_FRAC_BITS = gncd_pkg::GradFracDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  gncd_pkg::t_hash_out          i_data,
    output logic                         o_valid,
    output logic signed [GRADIENT_FRAC_BITS:0] o_gx,
    output logic signed [GRADIENT_FRAC_BITS:0] o_gy,
    output gncd_pkg::t_ofs               o_ofs
);
    localparam int N  = (CORDIC_STAGES > gncd_pkg::MaxStages) ?
                        gncd_pkg::MaxStages : CORDIC_STAGES;
    localparam int F  = GRADIENT_FRAC_BITS;
    localparam int Sh = 30 - F;
    localparam int W  = gncd_pkg::CrdW;

    logic [N:0]             r_v;
    logic signed [W-1:0]    r_x [N+1];
    logic signed [W-1:0]    r_y [N+1];
    logic signed [32:0]     r_z [N+1];
    logic [N:0]             r_f;
    gncd_pkg::t_ofs         r_o [N+1];
    logic [31:0]            fold;

    assign fold = i_data.flip ? (i_data.ang ^ 32'h8000_0000) : i_data.ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= gncd_pkg::CordicX0;
            r_y[0] <= '0;
            r_z[0] <= 33'(signed'(fold));
            r_f[0] <= i_data.flip;
            r_o[0] <= i_data.ofs;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [31:0] At = gncd_pkg::atan_turn(5'(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][32]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - 33'(At);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + 33'(At);
                end
                r_f[i+1] <= r_f[i];
                r_o[i+1] <= r_o[i];
            end
        end
    end

    function automatic logic signed [F:0] to_grad(input logic signed [W-1:0] v);
        logic signed [W:0] t;
        logic signed [W:0] lim;
        t   = (Sh > 0) ? ((W+1)'(v) + ((W+1)'(1) <<< (Sh > 0 ? Sh-1 : 0))) >>> Sh
                       : (W+1)'(v);
        lim = (W+1)'(1) <<< F;
        if (t > lim - 1) t = lim - 1;
        if (t < -lim)    t = -lim;
        return t[F:0];
    endfunction

    logic signed [W-1:0] xo, yo;
    assign xo = r_f[N] ? -r_x[N] : r_x[N];
    assign yo = r_f[N] ? -r_y[N] : r_y[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_gx  <= to_grad(yo);
            o_gy  <= to_grad(xo);
            o_ofs <= r_o[N];
        end
    end
endmodule

/* hdl/gncd_dot.sv */
// ----------------------------------------------------------------------------
// gncd_dot
// Offset dot gradient: products, sum, round and saturate, three stages.
// ----------------------------------------------------------------------------
module gncd_dot #(
    parameter int GRADIENT_FRAC_BITS = gncd_pkg::GradFracDef
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [GRADIENT_FRAC_BITS:0] i_gx,
    input  logic signed [GRADIENT_FRAC_BITS:0] i_gy,
    input  gncd_pkg::t_ofs                     i_ofs,
    output logic                               o_valid,
    output logic signed [gncd_pkg::OutW-1:0]   o_dot
);
    localparam int F  = GRADIENT_FRAC_BITS;
    localparam int Pw = 33 + F + 1;
    localparam int Sw = Pw + 1;
    localparam int Ow = gncd_pkg::OutW;

    logic [2:0]            r_v;
    logic signed [Pw-1:0]  r_px, r_py;
    logic signed [Sw-1:0]  r_s;
    logic signed [Sw-1:0]  rs;
    logic signed [Sw-1:0]  omax, omin;

    assign rs   = (r_s + (Sw'(1) <<< (F-1))) >>> F;
    assign omax = (Sw'(1) <<< (Ow-1)) - 1;
    assign omin = -(Sw'(1) <<< (Ow-1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= Pw'(i_ofs.dx) * Pw'(i_gx);
            r_py <= Pw'(i_ofs.dy) * Pw'(i_gy);
            r_s  <= Sw'(r_px) + Sw'(r_py);
            if (rs > omax)      o_dot <= omax[Ow-1:0];
            else if (rs < omin) o_dot <= omin[Ow-1:0];
            else                o_dot <= rs[Ow-1:0];
        end
    end

    assign o_valid = r_v[2];
endmodule

/* hdl/gradient_noise_corner_dot_top.sv */
// ----------------------------------------------------------------------------
// gradient_noise_corner_dot_top
// One corner term of 2-D gradient noise: hash, CORDIC gradient, dot product.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: i_valid with i_corner_x/y and i_point_x/y (Q16.16);
//    a request is taken when i_valid is high and o_stall is low.
//  - Result channel: o_valid with o_dot_value (Q18.16); taken when o_valid
//    is high and i_stall is low.
//  - Seed port: i_cfg_valid / o_cfg_ready with i_cfg_data; write only while
//    no request is in flight.
//  - Throughput: one request per cycle while the pipe is not stalled.
//  - Pipeline: hash, then CORDIC gradient with one registered stage per
//    iteration, then dot product.
//  - Stall: the whole pipe freezes while the output holds an untaken
//    result; o_stall is high exactly then, so nothing is lost or repeated.
//  - Reset: synchronous, clears all valid bits and the seed to zero.
// ----------------------------------------------------------------------------
module gradient_noise_corner_dot_top #(
    parameter int CORDIC_STAGES      = gncd_pkg::CordicStagesDef,
    parameter int GRADIENT_FRAC_BITS = gncd_pkg::GradFracDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_corner_x,
    input  logic signed [15:0] i_corner_y,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [33:0] o_dot_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    logic [31:0]           r_noise_seed;
    logic                  en;
    logic                  h_v, c_v;
    gncd_pkg::t_hash_out   h_d;
    logic signed [GRADIENT_FRAC_BITS:0] c_gx, c_gy;
    gncd_pkg::t_ofs        c_o;

    // pipeline advances unless the output holds a result not yet taken
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_seed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_noise_seed <= i_cfg_data;
        end
    end

    gncd_hash u_hash (
        .i_clk, .i_rst_n, .i_en(en), .i_valid,
        .i_seed(r_noise_seed),
        .i_corner_x, .i_corner_y, .i_point_x, .i_point_y,
        .o_valid(h_v), .o_data(h_d)
    );

    gncd_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES), .GRADIENT_FRAC_BITS(GRADIENT_FRAC_BITS)
    ) u_cordic (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(h_v), .i_data(h_d),
        .o_valid(c_v), .o_gx(c_gx), .o_gy(c_gy), .o_ofs(c_o)
    );

    gncd_dot #(.GRADIENT_FRAC_BITS(GRADIENT_FRAC_BITS)) u_dot (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(c_v),
        .i_gx(c_gx), .i_gy(c_gy), .i_ofs(c_o),
        .o_valid, .o_dot(o_dot_value)
    );

    // a stalled result must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dot_value))
        else $error("result changed under stall");
    // back-pressure only ever comes from the output side
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");
    // a lone seed write settles next cycle
    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_noise_seed == $past(i_cfg_data))
        else $error("seed write lost");
endmodule
